>>> hw/rtl/ssd_pkg.sv
`default_nettype none

package ssd_pkg;

  // Number of digit positions on the display
  localparam int unsigned Digits = 4;
  localparam int unsigned PosW   = $clog2(Digits);

  // Item function codes
  localparam logic [1:0] FuncLoad = 2'd0;
  localparam logic [1:0] FuncTick = 2'd1;
  localparam logic [1:0] FuncChar = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] RegApostrophe = 2'd0;
  localparam logic [1:0] RegColon      = 2'd1;
  localparam logic [1:0] RegPoint      = 2'd2;

  // ASCII codes used by the driver
  localparam logic [7:0] AsciiBlank = 8'h00;
  localparam logic [7:0] AsciiZero  = 8'h30;
  localparam logic [7:0] AsciiMinus = 8'h2D;

  // Displayable range of a loaded number
  localparam logic signed [15:0] NumMax = 16'sd9999;
  localparam logic signed [15:0] NumMin = -16'sd999;

  // Segment patterns, bit0 is segment a
  localparam logic [6:0] SegMinus = 7'h40;
  localparam logic [6:0] SegOff   = 7'h00;
  localparam logic [15:0][6:0] HexSeg = {
    7'h71, 7'h79, 7'h5E, 7'h39, 7'h7C, 7'h77, 7'h6F, 7'h7F,
    7'h07, 7'h7D, 7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F
  };

  typedef logic [7:0] char_t;
  typedef char_t [Digits-1:0] char_row_t;

  typedef struct packed {
    logic [1:0]        func;
    logic signed [15:0] number;
    logic [7:0]        char_code;
    logic [PosW-1:0]   char_position;
  } ssd_in_t;

  typedef struct packed {
    logic [PosW-1:0] digit_select;
    logic [6:0]      segments;
    logic            point_lit;
    logic            colon_lit;
    logic            apostrophe_lit;
  } ssd_out_t;

  typedef struct packed {
    logic            apostrophe_enable;
    logic            colon_enable;
    logic [PosW-1:0] point_position;
  } ssd_cfg_t;

  // Character to segment pattern: hex digits, minus, everything else off
  function automatic logic [6:0] seg_decode(input char_t c);
    logic [6:0] seg;
    seg = SegOff;
    if (c[7:4] == 4'h3 && c[3:0] <= 4'd9) begin
      seg = HexSeg[c[3:0]];
    end else if (c[7:3] == 5'b01000 && c[2:0] != 3'd0 && c[2:0] <= 3'd6) begin
      seg = HexSeg[4'({1'b0, c[2:0]} + 4'd9)];
    end else if (c == AsciiMinus) begin
      seg = SegMinus;
    end
    return seg;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/ssd_num_conv.sv
`default_nettype none

module ssd_num_conv import ssd_pkg::*; (
  input  logic signed [15:0] number_i,
  output char_row_t          chars_o
);

  logic        over;
  logic        neg;
  logic [15:0] mag16;
  logic [13:0] mag;
  logic [29:0] p1, p2, p3;
  logic [9:0]  q1;
  logic [6:0]  q2;
  logic [3:0]  q3;
  logic [13:0] r0;
  logic [9:0]  r1;
  logic [6:0]  r2;

  // Range check and magnitude
  assign over  = (number_i > NumMax) || (number_i < NumMin);
  assign neg   = number_i[15];
  assign mag16 = neg ? 16'(-number_i) : 16'(number_i);
  assign mag   = mag16[13:0];

  // Quotients by 10, 100 and 1000 via reciprocal multiply (exact up to 9999)
  assign p1 = 30'(mag) * 30'd52429;
  assign p2 = 30'(mag) * 30'd5243;
  assign p3 = 30'(mag) * 30'd8389;
  assign q1 = p1[28:19];
  assign q2 = p2[25:19];
  assign q3 = p3[26:23];

  // Remainders give the decimal digits
  assign r0 = mag - (14'(q1) * 14'd10);
  assign r1 = q1 - (10'(q2) * 10'd10);
  assign r2 = q2 - (7'(q3) * 7'd10);

  // Characters with leading blanking and sign; out of range shows all minus
  always_comb begin
    chars_o[0] = AsciiZero | {4'h0, r0[3:0]};
    chars_o[1] = (q1 != '0) ? (AsciiZero | {4'h0, r1[3:0]}) : AsciiBlank;
    chars_o[2] = (q2 != '0) ? (AsciiZero | {4'h0, r2[3:0]}) : AsciiBlank;
    chars_o[3] = (q3 != '0) ? (AsciiZero | {4'h0, q3}) : AsciiBlank;
    if (neg) begin
      chars_o[Digits-1] = AsciiMinus;
    end
    if (over) begin
      chars_o = {Digits{AsciiMinus}};
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/ssd_exec.sv
`default_nettype none

module ssd_exec import ssd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  ssd_cfg_t cfg_i,
  input  logic     item_valid_i,
  input  ssd_in_t  item_i,
  output logic     item_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output ssd_out_t out_data_o
);

  char_row_t       chars_q, chars_d;
  char_row_t       conv_chars;
  logic [PosW-1:0] scan_q, scan_d;
  logic            out_valid_q, out_valid_d;
  ssd_out_t        out_q, out_d;
  logic            is_tick;
  logic            take;
  logic [PosW-1:0] next_pos;

  ssd_num_conv u_conv (
    .number_i (item_i.number),
    .chars_o  (conv_chars)
  );

  // A tick needs room in the result register; other items always go
  assign is_tick      = (item_i.func == FuncTick);
  assign item_ready_o = !is_tick || !out_valid_q || out_ready_i;
  assign take         = item_valid_i && item_ready_o;
  assign next_pos     = scan_q + 1'b1;

  // Item execution: store update, scan advance, result build
  always_comb begin
    chars_d     = chars_q;
    scan_d      = scan_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (take) begin
      unique case (item_i.func)
        FuncLoad: begin
          chars_d = conv_chars;
        end
        FuncChar: begin
          chars_d[item_i.char_position] = item_i.char_code;
        end
        FuncTick: begin
          scan_d               = next_pos;
          out_valid_d          = 1'b1;
          out_d.digit_select   = next_pos;
          out_d.segments       = seg_decode(chars_q[next_pos]);
          out_d.point_lit      = (next_pos == cfg_i.point_position) && (next_pos != '0);
          out_d.colon_lit      = cfg_i.colon_enable;
          out_d.apostrophe_lit = cfg_i.apostrophe_enable;
        end
        default: begin
        end
      endcase
    end
  end

  // Control and character store
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chars_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      chars_q     <= chars_d;
      scan_q      <= scan_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

>>> hw/rtl/seven_segment_scan_driver.sv
`default_nettype none

// Path: a tick's result passes the input register, then the result register.
// Loads and character writes take effect for a tick transferred in the next
// cycle.
// Throughput: one item per cycle; the result register only holds the input
// side back when a tick meets a stalled result.
// Reset: scan position 0, all characters blank, valid flags and configuration 0.
module seven_segment_scan_driver import ssd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  ssd_in_t    in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output ssd_out_t   out_data_o,
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [1:0] cfg_data_i
);

  ssd_cfg_t cfg_q;
  logic     in_valid_q;
  ssd_in_t  in_q;
  logic     item_ready;

  // Configuration registers, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegApostrophe: cfg_q.apostrophe_enable <= cfg_data_i[0];
        RegColon:      cfg_q.colon_enable      <= cfg_data_i[0];
        RegPoint:      cfg_q.point_position    <= cfg_data_i[PosW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Input register
  assign in_ready_o = !in_valid_q || item_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  ssd_exec u_exec (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (in_valid_q),
    .item_i       (in_q),
    .item_ready_o (item_ready),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  // Held item is never dropped while the execute side stalls
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !item_ready |=> in_valid_q && $stable(in_q))
    else $error("held input item lost");

  // A new result only follows a tick
  a_tick_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_q && in_q.func == FuncTick))
    else $error("result without tick");

  // Position zero never shows the decimal point
  a_no_point_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(out_data_o.point_lit && out_data_o.digit_select == '0))
    else $error("point lit at position zero");

endmodule

`default_nettype wire
